// File: rtl/kmh_pkg.sv
`default_nettype none

package kmh_pkg;

  // Storage sizes.
  localparam int KmerMax     = 32;
  localparam int SketchDepth = 1024;
  localparam int AddrW       = 10;
  localparam int CntW        = 11;
  localparam int KmerW       = 6;
  localparam int WinW        = 8 * KmerMax;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 32;

  // Hash constants.
  localparam logic [63:0] MixC1  = 64'h87c37b91114253d5;
  localparam logic [63:0] MixC2  = 64'h4cf5ad432745937f;
  localparam logic [63:0] FmixM1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FmixM2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] H1Add  = 64'h0000000052dce729;
  localparam logic [63:0] H2Add  = 64'h0000000038495ab5;

  // Characters.
  localparam logic [7:0] ChA       = 8'h41;
  localparam logic [7:0] ChC       = 8'h43;
  localparam logic [7:0] ChG       = 8'h47;
  localparam logic [7:0] ChT       = 8'h54;
  localparam logic [7:0] LowerLo   = 8'd96;
  localparam logic [7:0] LowerHi   = 8'd123;
  localparam logic [7:0] CaseShift = 8'd32;

  typedef enum logic [1:0] {
    KIND_BASE  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KMER_LENGTH  = 3'd0,
    CFG_SKETCH_SIZE  = 3'd1,
    CFG_HASH_SEED    = 3'd2,
    CFG_WIDE_HASH    = 3'd3,
    CFG_FORWARD_ONLY = 3'd4,
    CFG_KEEP_CASE    = 3'd5
  } cfg_idx_e;

  function automatic logic [7:0] complement(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      ChA:     r = ChT;
      ChT:     r = ChA;
      ChC:     r = ChG;
      ChG:     r = ChC;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

endpackage

`default_nettype wire

// File: rtl/kmh_if.sv
`default_nettype none

// Input channel: one sequence byte, read request or clear per transfer.
interface kmh_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] base;
  logic       last;
  logic [9:0] index;

  modport source (output valid, kind, base, last, index, input ready);
  modport sink   (input valid, kind, base, last, index, output ready);
endinterface

// Output channel: one result per accepted input item.
interface kmh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        value_valid;
  logic        inserted;
  logic [10:0] entry_count;

  modport source (output valid, value, value_valid, inserted, entry_count, input ready);
  modport sink   (input valid, value, value_valid, inserted, entry_count, output ready);
endinterface

`default_nettype wire

// File: rtl/kmer_minhash_bottom_k_sketch.sv
`default_nettype none

// Bottom-k MinHash sketch of canonical k-mers, hashed with the x64 128-bit Murmur3 hash
// (low 64 or 32 bits of the first half). One item is handled at a time and
// in_i.ready is high only while the block is idle. A sequence byte that does not
// yet complete a k-mer, a clear or an unused kind goes straight to the done state,
// and a read passes through the read state first. A byte that completes a k-mer runs
// the bytewise strand compare, the 16-byte blocks, the tail and the final mixing
// (each 64-bit product takes three passes through one 32x32 multiplier), then a
// scan over the sketch entries below the new hash for the sorted position and a
// shift up of the larger entries one by one on insertion, since the 1024-entry sketch
// memory has one read and one write port. The result waits in an output
// register, so a stalled consumer only holds the block once a second result is
// ready. No clearing pass follows reset.
module kmer_minhash_bottom_k_sketch
  import kmh_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [CfgIdxW-1:0]   cfg_idx_i,
  input  wire [CfgDataW-1:0]  cfg_data_i,
  kmh_in_if.sink              in_i,
  kmh_out_if.source           out_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_CMP, S_BLK, S_B1, S_B2, S_B3, S_B4, S_B5, S_B6,
    S_TAIL, S_T1, S_T2, S_T3, S_T4, S_T5,
    S_FIN, S_F2, S_FM0, S_FM1, S_FM2, S_F3, S_MUL,
    S_SRD, S_SCMP, S_SDEC, S_SHR, S_SHW, S_RD, S_DONE
  } state_e;

  // Configuration registers.
  logic [KmerW-1:0] klen_cfg_q;
  logic [CntW-1:0]  size_q;
  logic [31:0]      seed_q;
  logic             wide_q, fwd_only_q, keep_case_q;

  // Windows and sequencing state.
  logic [KmerMax-1:0][7:0] fwin_q, rwin_q;
  logic [KmerW-1:0]        bases_q;
  state_e                  state_q, ret_q;
  logic [WinW-1:0]         kmer_q, rwork_q, cf_q, cr_q;
  logic [KmerW-1:0]        klen_q, cnt_q;
  logic [63:0]             h1_q, h2_q, k1_q, k2_q, h_q;
  logic [1:0]              blk_q;
  logic                    fm_sel_q;
  logic [63:0]             mul_a_q, mul_b_q, acc_q;
  logic [1:0]              mul_ph_q;
  logic [CntW-1:0]         fill_q, pos_q, j_q;
  logic                    dup_q;

  // Result and output registers.
  logic [63:0]             res_value_q, out_value_q;
  logic                    res_valid_q, res_ins_q;
  logic                    out_vld_q, out_vv_q, out_ins_q;
  logic [CntW-1:0]         out_cnt_q;

  // Sketch memory.
  logic [63:0]             mem [SketchDepth];
  logic [63:0]             rdata_q;
  logic [AddrW-1:0]        raddr, waddr;
  logic [63:0]             wdata;
  logic                    we;

  // Effective k-mer length and sketch capacity.
  logic [KmerW-1:0] k_eff;
  logic [CntW-1:0]  cap, new_cap;
  always_comb begin
    if (klen_cfg_q == '0) begin
      k_eff = KmerW'(1);
    end else if (klen_cfg_q > KmerW'(KmerMax)) begin
      k_eff = KmerW'(KmerMax);
    end else begin
      k_eff = klen_cfg_q;
    end
    cap     = (size_q > CntW'(SketchDepth)) ? CntW'(SketchDepth) : size_q;
    new_cap = (cfg_data_i[CntW-1:0] > CntW'(SketchDepth)) ? CntW'(SketchDepth)
                                                          : cfg_data_i[CntW-1:0];
  end

  // Incoming byte, window shift and alignment of the forward k-mer.
  logic [7:0]              b_fold;
  logic [KmerMax-1:0][7:0] new_fw, new_rw;
  logic [KmerW-1:0]        new_bases;
  logic [8:0]              align_sh;
  logic [WinW-1:0]         fwork, kmask;
  always_comb begin
    b_fold = in_i.base;
    if (!keep_case_q && in_i.base > LowerLo && in_i.base < LowerHi) begin
      b_fold = in_i.base - CaseShift;
    end
    new_fw    = {b_fold, fwin_q[KmerMax-1:1]};
    new_rw    = {rwin_q[KmerMax-2:0], complement(b_fold)};
    new_bases = (bases_q < KmerW'(KmerMax)) ? bases_q + KmerW'(1) : bases_q;
    align_sh  = {KmerW'(KmerMax) - k_eff, 3'b000};
    fwork     = WinW'(new_fw) >> align_sh;
    kmask     = {WinW{1'b1}} >> align_sh;
  end

  // Shared 32x32 multiplier: a 64-bit product takes three partial products.
  logic [31:0] ma, mb;
  logic [63:0] prod;
  always_comb begin
    ma   = (mul_ph_q == 2'd2) ? mul_a_q[63:32] : mul_a_q[31:0];
    mb   = (mul_ph_q == 2'd1) ? mul_b_q[63:32] : mul_b_q[31:0];
    prod = ma * mb;
  end

  // Hash helpers.
  logic [KmerW-1:0] tail_len;
  logic [1:0]       nblocks;
  logic [63:0]      len64, fm_src, acc_fx, x_b2, x_b5, fin_h1, fin_h2;
  always_comb begin
    tail_len = {2'b00, klen_q[3:0]};
    nblocks  = klen_q[5:4];
    len64    = {58'd0, klen_q};
    fm_src   = fm_sel_q ? h2_q : h1_q;
    acc_fx   = acc_q ^ (acc_q >> 33);
    x_b2     = rotl64(h1_q ^ acc_q, 27) + h2_q;
    x_b5     = rotl64(h2_q ^ acc_q, 31) + h1_q;
    fin_h2   = h2_q ^ len64;
    fin_h1   = (h1_q ^ len64) + fin_h2;
  end

  // Sketch memory ports.
  always_comb begin
    we    = 1'b0;
    waddr = pos_q[AddrW-1:0];
    wdata = h_q;
    unique case (state_q)
      S_IDLE:  raddr = in_i.index;
      S_SRD:   raddr = pos_q[AddrW-1:0];
      S_SHR:   raddr = AddrW'(j_q - CntW'(1));
      default: raddr = pos_q[AddrW-1:0];
    endcase
    if (state_q == S_SHW) begin
      we    = 1'b1;
      waddr = j_q[AddrW-1:0];
      wdata = rdata_q;
    end else if (state_q == S_SHR && !(j_q > pos_q)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_vld_q;
  assign out_o.value       = out_value_q;
  assign out_o.value_valid = out_vv_q;
  assign out_o.inserted    = out_ins_q;
  assign out_o.entry_count = out_cnt_q;

  // Sequencer, configuration and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_cfg_q  <= KmerW'(21);
      size_q      <= CntW'(1000);
      seed_q      <= 32'd42;
      wide_q      <= 1'b1;
      fwd_only_q  <= 1'b0;
      keep_case_q <= 1'b0;
      fwin_q      <= '0;
      rwin_q      <= '0;
      bases_q     <= '0;
      fill_q      <= '0;
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      out_vld_q   <= 1'b0;
      mul_ph_q    <= '0;
    end else begin
      // The output register empties on a transfer unless a new result replaces it.
      if (out_vld_q && out_o.ready && state_q != S_DONE) begin
        out_vld_q <= 1'b0;
      end

      // Register writes must arrive only while idle; the block itself does not enforce this.
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_KMER_LENGTH:  klen_cfg_q <= cfg_data_i[KmerW-1:0];
          CFG_SKETCH_SIZE: begin
            size_q <= cfg_data_i[CntW-1:0];
            if (fill_q > new_cap) begin
              fill_q <= new_cap;
            end
          end
          CFG_HASH_SEED:    seed_q      <= cfg_data_i;
          CFG_WIDE_HASH:    wide_q      <= cfg_data_i[0];
          CFG_FORWARD_ONLY: fwd_only_q  <= cfg_data_i[0];
          CFG_KEEP_CASE:    keep_case_q <= cfg_data_i[0];
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            res_value_q <= '0;
            res_ins_q   <= 1'b0;
            case (in_i.kind)
              KIND_BASE: begin
                if (in_i.last) begin
                  fwin_q  <= '0;
                  rwin_q  <= '0;
                  bases_q <= '0;
                end else begin
                  fwin_q  <= new_fw;
                  rwin_q  <= new_rw;
                  bases_q <= new_bases;
                end
                res_valid_q <= 1'b0;
                klen_q      <= k_eff;
                kmer_q      <= fwork;
                rwork_q     <= WinW'(new_rw) & kmask;
                cf_q        <= fwork;
                cr_q        <= WinW'(new_rw);
                cnt_q       <= '0;
                if (new_bases >= k_eff) begin
                  state_q <= S_CMP;
                end else begin
                  state_q <= S_DONE;
                end
              end
              KIND_READ: begin
                res_valid_q <= ({1'b0, in_i.index} < fill_q);
                state_q     <= S_RD;
              end
              KIND_CLEAR: begin
                res_valid_q <= 1'b0;
                fill_q      <= '0;
                fwin_q      <= '0;
                rwin_q      <= '0;
                bases_q     <= '0;
                state_q     <= S_DONE;
              end
              default: begin
                res_valid_q <= 1'b0;
                state_q     <= S_DONE;
              end
            endcase
          end
        end

        S_RD: begin
          if (res_valid_q) begin
            res_value_q <= rdata_q;
          end
          state_q <= S_DONE;
        end

        // Bytewise strand compare, one byte a cycle; ties keep the forward k-mer.
        S_CMP: begin
          h1_q  <= {32'd0, seed_q};
          h2_q  <= {32'd0, seed_q};
          blk_q <= '0;
          if (fwd_only_q || cnt_q == klen_q) begin
            state_q <= S_BLK;
          end else if (cf_q[7:0] != cr_q[7:0]) begin
            if (cf_q[7:0] > cr_q[7:0]) begin
              kmer_q <= rwork_q;
            end
            state_q <= S_BLK;
          end else begin
            cf_q  <= cf_q >> 8;
            cr_q  <= cr_q >> 8;
            cnt_q <= cnt_q + KmerW'(1);
          end
        end

        // Full 16-byte blocks.
        S_BLK: begin
          if (blk_q < nblocks) begin
            k1_q     <= kmer_q[{blk_q[0], 7'd0} +: 64];
            k2_q     <= kmer_q[{blk_q[0], 7'd64} +: 64];
            mul_a_q  <= kmer_q[{blk_q[0], 7'd0} +: 64];
            mul_b_q  <= MixC1;
            ret_q    <= S_B1;
            state_q  <= S_MUL;
          end else begin
            k1_q    <= kmer_q[{nblocks[0], 7'd0} +: 64];
            k2_q    <= kmer_q[{nblocks[0], 7'd64} +: 64];
            state_q <= S_TAIL;
          end
        end
        S_B1: begin
          mul_a_q <= rotl64(acc_q, 31);
          mul_b_q <= MixC2;
          ret_q   <= S_B2;
          state_q <= S_MUL;
        end
        S_B2: begin
          h1_q    <= x_b2;
          state_q <= S_B3;
        end
        S_B3: begin
          h1_q    <= (h1_q << 2) + h1_q + H1Add;
          mul_a_q <= k2_q;
          mul_b_q <= MixC2;
          ret_q   <= S_B4;
          state_q <= S_MUL;
        end
        S_B4: begin
          mul_a_q <= rotl64(acc_q, 33);
          mul_b_q <= MixC1;
          ret_q   <= S_B5;
          state_q <= S_MUL;
        end
        S_B5: begin
          h2_q    <= x_b5;
          state_q <= S_B6;
        end
        S_B6: begin
          h2_q    <= (h2_q << 2) + h2_q + H2Add;
          blk_q   <= blk_q + 2'd1;
          state_q <= S_BLK;
        end

        // Tail bytes beyond the last full block.
        S_TAIL: begin
          if (tail_len > KmerW'(8)) begin
            mul_a_q <= k2_q;
            mul_b_q <= MixC2;
            ret_q   <= S_T1;
            state_q <= S_MUL;
          end else begin
            state_q <= S_T3;
          end
        end
        S_T1: begin
          mul_a_q <= rotl64(acc_q, 33);
          mul_b_q <= MixC1;
          ret_q   <= S_T2;
          state_q <= S_MUL;
        end
        S_T2: begin
          h2_q    <= h2_q ^ acc_q;
          state_q <= S_T3;
        end
        S_T3: begin
          if (tail_len != '0) begin
            mul_a_q <= k1_q;
            mul_b_q <= MixC1;
            ret_q   <= S_T4;
            state_q <= S_MUL;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_T4: begin
          mul_a_q <= rotl64(acc_q, 31);
          mul_b_q <= MixC2;
          ret_q   <= S_T5;
          state_q <= S_MUL;
        end
        S_T5: begin
          h1_q    <= h1_q ^ acc_q;
          state_q <= S_FIN;
        end

        // Length mix-in and final avalanche of both halves.
        S_FIN: begin
          h1_q    <= fin_h1;
          h2_q    <= fin_h2;
          state_q <= S_F2;
        end
        S_F2: begin
          h2_q     <= h2_q + h1_q;
          fm_sel_q <= 1'b0;
          state_q  <= S_FM0;
        end
        S_FM0: begin
          mul_a_q <= fm_src ^ (fm_src >> 33);
          mul_b_q <= FmixM1;
          ret_q   <= S_FM1;
          state_q <= S_MUL;
        end
        S_FM1: begin
          mul_a_q <= acc_fx;
          mul_b_q <= FmixM2;
          ret_q   <= S_FM2;
          state_q <= S_MUL;
        end
        S_FM2: begin
          if (fm_sel_q) begin
            h2_q    <= acc_fx;
            state_q <= S_F3;
          end else begin
            h1_q     <= acc_fx;
            fm_sel_q <= 1'b1;
            state_q  <= S_FM0;
          end
        end
        S_F3: begin
          h_q         <= wide_q ? h1_q + h2_q : {32'd0, h1_q[31:0] + h2_q[31:0]};
          res_value_q <= wide_q ? h1_q + h2_q : {32'd0, h1_q[31:0] + h2_q[31:0]};
          res_valid_q <= 1'b1;
          pos_q       <= '0;
          dup_q       <= 1'b0;
          state_q     <= S_SRD;
        end

        // One partial product per cycle into the accumulator.
        S_MUL: begin
          if (mul_ph_q == 2'd0) begin
            acc_q <= prod;
          end else begin
            acc_q <= acc_q + {prod[31:0], 32'd0};
          end
          if (mul_ph_q == 2'd2) begin
            mul_ph_q <= '0;
            state_q  <= ret_q;
          end else begin
            mul_ph_q <= mul_ph_q + 2'd1;
          end
        end

        // Scan for the sorted position of the new hash.
        S_SRD: begin
          state_q <= (pos_q < fill_q) ? S_SCMP : S_SDEC;
        end
        S_SCMP: begin
          if (rdata_q < h_q) begin
            pos_q   <= pos_q + CntW'(1);
            state_q <= S_SRD;
          end else begin
            dup_q   <= (rdata_q == h_q);
            state_q <= S_SDEC;
          end
        end
        S_SDEC: begin
          if (dup_q || pos_q >= cap) begin
            state_q <= S_DONE;
          end else begin
            j_q     <= (fill_q < cap) ? fill_q : cap - CntW'(1);
            state_q <= S_SHR;
          end
        end

        // Shift larger entries up by one, then write the new hash.
        S_SHR: begin
          if (j_q > pos_q) begin
            state_q <= S_SHW;
          end else begin
            if (fill_q < cap) begin
              fill_q <= fill_q + CntW'(1);
            end
            res_ins_q <= 1'b1;
            state_q   <= S_DONE;
          end
        end
        S_SHW: begin
          j_q     <= j_q - CntW'(1);
          state_q <= S_SHR;
        end

        // Hand the result to the output register once it is free.
        S_DONE: begin
          if (!out_vld_q || out_o.ready) begin
            out_vld_q   <= 1'b1;
            out_value_q <= res_value_q;
            out_vv_q    <= res_valid_q;
            out_ins_q   <= res_ins_q;
            out_cnt_q   <= fill_q;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // The fill never exceeds the memory depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(SketchDepth))
    else $error("sketch fill beyond depth");

  // An inserted hash is always a valid value and leaves a nonempty sketch.
  a_ins_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_ins_q) |-> (out_vv_q && out_cnt_q != '0))
    else $error("insertion reported without a valid hash");

  // An accepted item keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted back to back");

  // The multiplier phase only advances inside a multiplication.
  a_mul_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_MUL) |-> (mul_ph_q == 2'd0))
    else $error("multiplier phase left open");
`endif

endmodule

`default_nettype wire
